// ----- design/kpsa_pkg.sv -----
package kpsa_pkg;

  // keypad geometry
  localparam int unsigned ROWS     = 4;
  localparam int unsigned COLS     = 4;
  localparam int unsigned MAP_W    = 16;
  localparam int unsigned KEYS_RAW = ROWS * COLS;
  localparam int unsigned KEYS     = (KEYS_RAW > MAP_W) ? MAP_W : KEYS_RAW;

  localparam int unsigned CODE_W   = 5;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX           = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET  = CNT_W'(30);
  localparam logic [CNT_W-1:0] REPEAT_RESET      = CNT_W'(5);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = CFG_IDX_W'(1);

  // item kinds carried in tuser
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic                 func;
    logic [CODE_W-1:0]    code;
  } step_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
  } cfg_wr_t;

endpackage

// ----- design/keypad_scan_autorepeat.sv -----
// matrix keypad scanner with auto-repeat. a tick transaction (tuser = 0) carries the
// pressed map in tdata and produces no output; a read transaction (tuser = 1) returns the
// latched key code (0 = none pending) and clears it. the map is priority encoded, lowest
// row then lowest column, to row*4+col+1. a fresh press latches its code; holding the same
// key counts ticks and relatches once the count reaches long_press_ticks, after which
// repeat_ticks is taken off the count (clamped at 0). one transaction is accepted every
// cycle unless the input stalls: the input register feeds the scan/hold logic, whose state
// updates when the item advances out of it; a read's code then loads the output register.
// the input only stalls while a read finds the output register full and not being taken.
// configuration writes are taken every cycle and should be issued while the block is idle.
module keypad_scan_autorepeat
  import kpsa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,   // [15:0] pressed_map
  input  logic                   s_axis_tuser_i,   // [0] func
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,   // [4:0] key_code, [7:5] zero
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CNT_W-1:0]       cfg_data_i
);

  // input register
  logic             in_valid_q, in_valid_d;
  logic             in_func_q;
  logic [MAP_W-1:0] in_map_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_code_q;

  logic              out_free;
  logic              advance;
  logic [CODE_W-1:0] scan_code;
  logic [CODE_W-1:0] rd_code;
  step_t             step;
  cfg_wr_t           cfg_wr;

  // a tick never needs the output slot, a read needs it free or draining
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (in_func_q == FUNC_TICK || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign in_valid_d = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload only loads on an accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_func_q <= s_axis_tuser_i;
      in_map_q  <= s_axis_tdata_i[MAP_W-1:0];
    end
  end

  kpsa_encode u_encode (
    .map_i  (in_map_q),
    .code_o (scan_code)
  );

  assign step.valid = advance;
  assign step.func  = in_func_q;
  assign step.code  = scan_code;

  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  kpsa_hold u_hold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .step_i    (step),
    .rd_code_o (rd_code)
  );

  // result register: filled by a read, emptied when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_func_q == FUNC_READ) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_func_q == FUNC_READ) begin
      out_code_q <= rd_code;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TDATA_OUT_W - CODE_W){1'b0}}, out_code_q};

endmodule

// ----- design/kpsa_encode.sv -----
module kpsa_encode
  import kpsa_pkg::*;
(
  input  logic [MAP_W-1:0]  map_i,
  output logic [CODE_W-1:0] code_o
);

  // lowest set bit wins: scan from the top so the lowest index is kept
  always_comb begin
    code_o = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (map_i[i]) begin
        code_o = CODE_W'(i + 1);
      end
    end
  end

endmodule

// ----- design/kpsa_hold.sv -----
module kpsa_hold
  import kpsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_wr_t           cfg_i,
  input  step_t             step_i,
  output logic [CODE_W-1:0] rd_code_o
);

  logic [CNT_W-1:0]  long_press_q, long_press_d;
  logic [CNT_W-1:0]  repeat_q, repeat_d;
  logic [CODE_W-1:0] prev_q, prev_d;
  logic [CODE_W-1:0] pending_q, pending_d;
  logic [CNT_W-1:0]  hold_q, hold_d;
  logic [CNT_W-1:0]  hold_inc;

  assign hold_inc  = (hold_q < CNT_MAX) ? hold_q + CNT_W'(1) : hold_q;
  assign rd_code_o = pending_q;

  always_comb begin
    long_press_d = long_press_q;
    repeat_d     = repeat_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_LONG_PRESS) begin
        long_press_d = cfg_i.data;
      end else if (cfg_i.index == REG_REPEAT) begin
        repeat_d = cfg_i.data;
      end
    end
  end

  always_comb begin
    prev_d    = prev_q;
    pending_d = pending_q;
    hold_d    = hold_q;
    if (step_i.valid) begin
      if (step_i.func == FUNC_READ) begin
        pending_d = '0;
      end else begin
        prev_d = step_i.code;
        if (step_i.code == '0) begin
          hold_d = '0;
        end else if (prev_q == '0) begin
          // fresh press
          pending_d = step_i.code;
          hold_d    = '0;
        end else if (step_i.code == prev_q) begin
          hold_d = hold_inc;
          if (hold_inc >= long_press_q) begin
            pending_d = step_i.code;
            hold_d    = (hold_inc > repeat_q) ? hold_inc - repeat_q : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
      repeat_q     <= REPEAT_RESET;
      prev_q       <= '0;
      pending_q    <= '0;
      hold_q       <= '0;
    end else begin
      long_press_q <= long_press_d;
      repeat_q     <= repeat_d;
      prev_q       <= prev_d;
      pending_q    <= pending_d;
      hold_q       <= hold_d;
    end
  end

`ifndef ASSERT_OFF
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && step_i.func == FUNC_READ |=> pending_q == '0)
    else $error("pending key not cleared by read");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && step_i.func == FUNC_TICK && step_i.code == '0 |=> hold_q == '0)
    else $error("hold counter not cleared on release");

  a_fresh_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && step_i.func == FUNC_TICK && step_i.code != '0 && prev_q == '0
    |=> pending_q == $past(step_i.code))
    else $error("fresh press not latched");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CODE_W'(KEYS))
    else $error("pending key out of range");
`endif

endmodule

// ----- test/tb_keypad_scan_autorepeat.sv -----
`timescale 1ns / 1ps

module tb_keypad_scan_autorepeat;
  import kpsa_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  // cycles to let the scan state settle after the last transaction
  localparam int SETTLE_CYCLES = 8;
  // an index that maps to no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef struct packed {
    logic             func;
    logic [MAP_W-1:0] map;
  } scan_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = FUNC_TICK;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [CNT_W-1:0]       cfg_data_i      = '0;

  keypad_scan_autorepeat dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [15:0] pressed_map
    .s_axis_tuser_i  (s_axis_tuser_i),   // [0] func
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [4:0] key_code, [7:5] zero
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // scanner shadow state, mirrors what the block should hold
  logic [CNT_W-1:0]  lp_thresh = LONG_PRESS_RESET;
  logic [CNT_W-1:0]  rp_step   = REPEAT_RESET;
  logic [CODE_W-1:0] prev_key  = '0;
  logic [CODE_W-1:0] pend_key  = '0;
  logic [CNT_W-1:0]  hold_cnt  = '0;

  // pending stimulus and the key codes that reads must return, oldest first
  scan_item_t        scan_items[$];
  logic [CODE_W-1:0] key_codes_due[$];
  scan_item_t        item_on_bus;
  logic [CODE_W-1:0] want_code;

  int items_queued  = 0;
  int items_taken   = 0;
  int ticks_sent    = 0;
  int reads_checked = 0;
  int presses_seen  = 0;
  int repeats_seen  = 0;
  int settings_used = 0;
  int fails         = 0;
  int idle_pct      = 0;
  int src_gap       = 0;
  int sink_gap      = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // priority encode: lowest row first, then lowest column
  function automatic logic [CODE_W-1:0] lowest_key(input logic [MAP_W-1:0] map);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (map[i]) code = CODE_W'(i + 1);
    end
    return code;
  endfunction

  // advance the shadow scanner by one accepted transaction
  task automatic predict_scan(input scan_item_t it);
    logic [CODE_W-1:0] cur;
    if (it.func == FUNC_READ) begin
      key_codes_due.push_back(pend_key);
      pend_key = '0;
    end else begin
      cur = lowest_key(it.map);
      if (cur != '0) begin
        if (prev_key == '0) begin
          // fresh press
          pend_key = cur;
          hold_cnt = '0;
          presses_seen++;
        end else if (cur == prev_key) begin
          // same key held, count saturates at the top
          if (hold_cnt != CNT_MAX) hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt >= lp_thresh) begin
            pend_key = cur;
            hold_cnt = (hold_cnt > rp_step) ? hold_cnt - rp_step : '0;
            repeats_seen++;
          end
        end
        // a different key while held latches nothing and keeps the count
      end else begin
        hold_cnt = '0;
      end
      prev_key = cur;
    end
  endtask

  task automatic push_tick(input logic [MAP_W-1:0] map);
    scan_items.push_back('{func: FUNC_TICK, map: map});
    items_queued++;
    ticks_sent++;
  endtask

  task automatic push_read();
    // map is don't-care on reads, randomize it anyway
    scan_items.push_back('{func: FUNC_READ, map: MAP_W'($urandom)});
    items_queued++;
  endtask

  // a map whose lowest set bit is key k, sometimes with other keys above it
  function automatic logic [MAP_W-1:0] map_on_key(input int k);
    logic [MAP_W-1:0] above;
    above = ~((MAP_W'(2) << k) - MAP_W'(1));
    if ($urandom_range(0, 1) == 0) return MAP_W'(1) << k;
    return (MAP_W'($urandom) & above) | (MAP_W'(1) << k);
  endfunction

  // press one key, hold it for a random stretch with reads and noise mixed in,
  // then release it or slide over to another key
  task automatic key_session(input int max_hold);
    int k;
    int n;
    int r;
    k = $urandom_range(0, KEYS - 1);
    push_tick(map_on_key(k));
    n = $urandom_range(0, max_hold);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 15) push_read();
      else if (r < 20) push_tick(MAP_W'($urandom));
      else push_tick(map_on_key(k));
    end
    if ($urandom_range(0, 3) != 0) push_tick('0);
    else push_tick(map_on_key((k + $urandom_range(1, KEYS - 1)) % KEYS));
    if ($urandom_range(0, 1) == 1) push_read();
  endtask

  // block until every queued transaction went in and every read came back,
  // then give the tick pipeline time to finish its last update
  task automatic wait_idle();
    while (items_taken != items_queued || key_codes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_LONG_PRESS) lp_thresh = val;
    else if (idx == REG_REPEAT) rp_step = val;
    settings_used++;
  endtask

  // reprogram both registers once idle, then queue random key sessions
  task automatic run_phase(input logic [CNT_W-1:0] lp, input logic [CNT_W-1:0] rp,
                           input int target, input int max_hold, input int idle);
    int start;
    wait_idle();
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_REPEAT, rp);
    idle_pct = idle;
    start = items_queued;
    while (items_queued - start < target) key_session(max_hold);
  endtask

  // source side: feeds the input stream from the pending queue with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_scan(item_on_bus);
        items_taken++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (scan_items.size() > 0) begin
          item_on_bus = scan_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= item_on_bus.map;
          s_axis_tuser_i  <= item_on_bus.func;
          if ($urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // sink side: backpressure in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) sink_gap = $urandom_range(1, 13);
    end
  end

  // result checker, every result transaction answers the oldest read
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (key_codes_due.size() == 0) begin
        $error("key_code: expected no result, got %0d", m_axis_tdata_o[CODE_W-1:0]);
        fails++;
      end else begin
        want_code = key_codes_due.pop_front();
        if (m_axis_tdata_o[CODE_W-1:0] !== want_code) begin
          $error("key_code: expected %0d, got %0d", want_code, m_axis_tdata_o[CODE_W-1:0]);
          fails++;
        end
        if (m_axis_tdata_o[TDATA_OUT_W-1:CODE_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata_o[TDATA_OUT_W-1:CODE_W]);
          fails++;
        end
        reads_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int k;
    int lp;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;

    // directed checks under the reset settings
    push_read();                 // nothing latched yet
    push_tick('0);
    push_read();
    push_tick(16'h0001);         // first key, fresh press
    push_read();
    push_read();                 // read clears the latch
    push_tick(16'h8000);         // key change while held latches nothing
    push_read();
    push_tick('0);
    push_tick(16'h8000);         // last key, fresh press
    push_read();
    push_tick(16'hFFFF);         // change back to first key while held
    push_read();
    push_tick('0);
    push_tick(16'hFFFF);         // all keys down, lowest wins
    push_read();
    push_tick(16'hF000);
    push_tick('0);
    push_tick(16'h1000);
    push_tick(16'h5000);         // same lowest key, counts as a hold
    push_read();
    while (items_queued < 90) key_session(45);

    // repeat on every held tick, shortest interval
    run_phase(1, 1, 80, 8, 30);
    // zero threshold and zero repeat step
    run_phase(0, 0, 70, 10, 10);

    // write to an unmapped index must not disturb anything
    wait_idle();
    write_reg(REG_UNUSED, CNT_W'($urandom));
    // long threshold with no step back: one long hold keeps repeating at the threshold
    run_phase(100, 0, 20, 4, 15);
    k = $urandom_range(0, KEYS - 1);
    push_tick(map_on_key(k));
    for (int i = 0; i < 120; i++) begin
      push_tick(map_on_key(k));
      if (i % 17 == 16) push_read();
    end
    push_read();
    push_tick('0);

    // step larger than any count, clamps to zero every repeat
    run_phase(2, 1023, 70, 10, 25);

    repeat (3) begin
      lp = $urandom_range(1, 12);
      run_phase(CNT_W'(lp), CNT_W'($urandom_range(0, 12)), 60, lp * 2 + 8,
                $urandom_range(5, 40));
    end

    // closing stretch with both sides always ready
    lp = $urandom_range(1, 6);
    run_phase(CNT_W'(lp), CNT_W'($urandom_range(1, 6)), 100, lp * 2 + 8, 0);

    wait_idle();
    if (key_codes_due.size() != 0) begin
      $error("key_code: %0d reads never answered", key_codes_due.size());
      fails++;
    end
    $display("covered %0d scan ticks and %0d checked reads across %0d register writes",
             ticks_sent, reads_checked, settings_used);
    $display("predicted %0d fresh presses and %0d auto-repeats", presses_seen, repeats_seen);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/kpsa_pkg.sv
design/kpsa_encode.sv
design/kpsa_hold.sv
design/keypad_scan_autorepeat.sv
test/tb_keypad_scan_autorepeat.sv
